[rtl/cfr_pkg.sv]
// Shared types, codes and SHA-256 constants of the checked frame receiver.
package cfr_pkg;

   localparam int HDR_LEN   = 39;
   localparam int MARK_POS0 = 0;
   localparam int MARK_POS1 = 5;
   localparam int MARK_POS2 = 38;

   // Largest body; the widths of read_index and message_length are sized for it.
   localparam int BODY_MAX  = 1024;

   // Request kinds, as decoded by the front end.
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   // Result outcomes.
   localparam logic [2:0] OC_ACCEPT     = 3'd0;
   localparam logic [2:0] OC_BAD_DIGEST = 3'd1;
   localparam logic [2:0] OC_GIVE_UP    = 3'd2;
   localparam logic [2:0] OC_TOO_LONG   = 3'd3;
   localparam logic [2:0] OC_TIMEOUT    = 3'd4;
   localparam logic [2:0] OC_READ       = 3'd5;

   // Message types.
   localparam logic [1:0] MT_TIME    = 2'd0;
   localparam logic [1:0] MT_INFO    = 2'd1;
   localparam logic [1:0] MT_CONTENT = 2'd2;
   localparam logic [1:0] MT_UNKNOWN = 2'd3;

   localparam logic [31:0] SHA_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [7:0]  frame_marker;
      logic [7:0]  ack_code;
      logic [7:0]  nack_code;
      logic [7:0]  time_type_code;
      logic [7:0]  file_info_type_code;
      logic [7:0]  file_content_type_code;
      logic [15:0] timeout_ticks;
      logic [3:0]  max_retries;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic [9:0] read_index;
   } item_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [7:0]  reply_byte;
      logic [1:0]  message_type;
      logic [10:0] message_length;
      logic [7:0]  read_data;
   } res_type;

endpackage

[rtl/cfr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cfr_sha.sv]
// SHA-256 compression unit: one round per cycle, holds the running hash state.
module cfr_sha (
   input  logic              clock,
   input  logic              reset,
   input  logic              init,
   input  logic              start,
   input  logic [15:0][31:0] words,
   output logic              busy,
   output logic              done,
   output logic [255:0]      digest
);

   import cfr_pkg::*;

   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  rnd_ff, rnd_in;
   logic        run_ff, run_in;
   logic        add_ff, add_in;
   logic [31:0] t1, t2, sig0, sig1, w_new;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   always_comb begin
      h_in   = h_ff;
      v_in   = v_ff;
      w_in   = w_ff;
      rnd_in = rnd_ff;
      run_in = run_ff;
      add_in = 1'b0;
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + SHA_K[rnd_ff] + w_ff[0];
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      sig0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sig1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + sig0 + w_ff[9] + sig1;
      if (init) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = SHA_IV[i];
         end
      end else if (start) begin
         v_in   = h_ff;
         for (int i = 0; i < 16; i++) begin
            w_in[i] = words[i];
         end
         rnd_in = 6'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = w_new;
         rnd_in   = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end else if (add_ff) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= SHA_IV[i];
         end
         run_ff <= 1'b0;
         add_ff <= 1'b0;
         rnd_ff <= 6'd0;
      end else begin
         h_ff   <= h_in;
         run_ff <= run_in;
         add_ff <= add_in;
         rnd_ff <= rnd_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[255-32*i -: 32] = h_ff[i];
      end
   end

   assign busy = run_ff | add_ff;
   assign done = add_ff;

endmodule

[rtl/cfr_front.sv]
// Front end: takes requests, decodes their kind and queues them in two entries.
module cfr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,
   input  logic [1:0]         req_tuser,
   output logic               item_valid,
   output cfr_pkg::item_type  item,
   input  logic               item_pop
);

   import cfr_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   incoming;

   always_comb begin
      incoming.kind       = req_tuser;
      incoming.rx_byte    = req_tdata[7:0];
      incoming.read_index = req_tdata[17:8];
   end

   assign req_tready = (cnt_ff != 2'd2);
   // An unused request kind causes nothing, so it is not queued.
   assign push       = req_tvalid && req_tready && (incoming.kind != KIND_NONE);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ item_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

[rtl/cfr_core.sv]
// Back end: frame parser, hashing sequencer, body banks and reply generation.
module cfr_core (
   input  logic              clock,
   input  logic              reset,
   input  cfr_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  cfr_pkg::item_type item,
   output logic              item_pop,
   input  logic              out_full,
   output logic              res_valid,
   output cfr_pkg::res_type  res
);

   import cfr_pkg::*;

   localparam int LEN_W  = $clog2(BODY_MAX + 1);
   localparam int POS_W  = $clog2(BODY_MAX);
   localparam int ADDR_W = $clog2(2 * BODY_MAX);
   localparam int CNT_W  = $clog2(HDR_LEN + BODY_MAX + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GO   = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_PAD1 = 3'd3;
   localparam logic [2:0] ST_PAD2 = 3'd4;
   localparam logic [2:0] ST_CMP  = 3'd5;
   localparam logic [2:0] ST_TYPE = 3'd6;
   localparam logic [2:0] ST_READ = 3'd7;

   localparam logic [1:0] PH_BODY = 2'd0;
   localparam logic [1:0] PH_PAD1 = 2'd1;
   localparam logic [1:0] PH_PAD2 = 2'd2;

   localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(BODY_MAX);

   logic [2:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic             fin_ff, fin_in;
   logic [CNT_W-1:0] bc_ff, bc_in;
   logic [31:0]      hl_ff, hl_in;
   logic             bad_ff, bad_in;
   logic [255:0]     exp_ff, exp_in;
   logic [7:0]       hb_ff [64];
   logic [7:0]       hb_in [64];
   logic             bank_ff, bank_in;
   logic [3:0]       retry_ff, retry_in;
   logic [15:0]      idle_ff, idle_in;
   logic [1:0]       type_ff, type_in;
   logic [LEN_W-1:0] llen_ff, llen_in;

   logic [7:0]        pad1 [64];
   logic [7:0]        pad2 [64];
   logic [5:0]        fill;
   logic              two_blocks;
   logic [63:0]       len_bits;
   logic [15:0][31:0] sha_words;
   logic              sha_init, sha_start, sha_busy, sha_done;
   logic [255:0]      sha_digest;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   logic [CNT_W-1:0] pos;
   logic [1:0]       len_sel;
   logic [15:0]      idle_next;
   logic             last_byte;
   logic             clr, rog, emit;
   logic [2:0]       rog_oc, e_oc;
   logic [7:0]       e_reply, e_data;
   logic [1:0]       new_type;

   // Padding blocks for the final compression(s).
   always_comb begin
      fill       = hl_ff[5:0];
      two_blocks = (fill >= 6'd56);
      len_bits   = {29'd0, hl_ff, 3'd0};
      for (int i = 0; i < 64; i++) begin
         if (i < int'(fill)) begin
            pad1[i] = hb_ff[i];
         end else if (i == int'(fill)) begin
            pad1[i] = 8'h80;
         end else begin
            pad1[i] = 8'h00;
         end
         pad2[i] = 8'h00;
      end
      for (int j = 0; j < 8; j++) begin
         if (!two_blocks) begin
            pad1[56+j] = len_bits[63-8*j -: 8];
         end
         pad2[56+j] = len_bits[63-8*j -: 8];
      end
      for (int i = 0; i < 16; i++) begin
         sha_words[i] = {hb_ff[4*i], hb_ff[4*i+1], hb_ff[4*i+2], hb_ff[4*i+3]};
      end
   end

   always_comb begin
      if (ram_rdata == cfg.time_type_code) begin
         new_type = MT_TIME;
      end else if (ram_rdata == cfg.file_info_type_code) begin
         new_type = MT_INFO;
      end else if (ram_rdata == cfg.file_content_type_code) begin
         new_type = MT_CONTENT;
      end else begin
         new_type = MT_UNKNOWN;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      bc_in     = bc_ff;
      hl_in     = hl_ff;
      bad_in    = bad_ff;
      exp_in    = exp_ff;
      hb_in     = hb_ff;
      bank_in   = bank_ff;
      retry_in  = retry_ff;
      idle_in   = idle_ff;
      type_in   = type_ff;
      llen_in   = llen_ff;
      item_pop  = 1'b0;
      sha_init  = 1'b0;
      sha_start = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = item.rx_byte;
      ram_re    = 1'b0;
      ram_raddr = '0;
      clr       = 1'b0;
      rog       = 1'b0;
      rog_oc    = OC_BAD_DIGEST;
      emit      = 1'b0;
      e_oc      = OC_READ;
      e_reply   = 8'h00;
      e_data    = 8'h00;
      pos       = bc_ff - CNT_W'(HDR_LEN);
      len_sel   = 2'(bc_ff - CNT_W'(1));
      idle_next = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      last_byte = ((32'(pos) + 32'd1) == hl_ff);

      case (state_ff)
         ST_IDLE: begin
            item_pop = item_valid && !out_full;
            if (item_pop) begin
               case (item.kind)
                  KIND_BYTE: begin
                     idle_in = 16'd0;
                     if (bc_ff < CNT_W'(HDR_LEN)) begin
                        if (bc_ff == CNT_W'(MARK_POS0) || bc_ff == CNT_W'(MARK_POS1) ||
                            bc_ff == CNT_W'(MARK_POS2)) begin
                           if (item.rx_byte != cfg.frame_marker) begin
                              bad_in = 1'b1;
                           end
                        end else if (bc_ff < CNT_W'(MARK_POS1)) begin
                           hl_in[8*len_sel +: 8] = item.rx_byte;
                        end else begin
                           exp_in = {exp_ff[247:0], item.rx_byte};
                        end
                        bc_in = bc_ff + CNT_W'(1);
                        if (bc_in == CNT_W'(HDR_LEN)) begin
                           if (bad_in) begin
                              clr = 1'b1;
                           end else if (hl_in[31] || hl_in > 32'(BODY_MAX)) begin
                              clr      = 1'b1;
                              retry_in = 4'd0;
                              emit     = 1'b1;
                              e_oc     = OC_TOO_LONG;
                           end else if (hl_in == 32'd0) begin
                              state_in = ST_PAD1;
                           end
                        end
                     end else if (32'(pos) >= hl_ff || 32'(pos) >= 32'(BODY_MAX)) begin
                        clr = 1'b1;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = (bank_ff ? '0 : BANK1_BASE)
                                  + ADDR_W'(pos[POS_W-1:0]);
                        hb_in[pos[5:0]] = item.rx_byte;
                        bc_in = bc_ff + CNT_W'(1);
                        if (pos[5:0] == 6'd63) begin
                           fin_in   = last_byte;
                           phase_in = PH_BODY;
                           state_in = ST_GO;
                        end else if (last_byte) begin
                           state_in = ST_PAD1;
                        end
                     end
                  end
                  KIND_TICK: begin
                     idle_in = idle_next;
                     if (idle_next >= cfg.timeout_ticks) begin
                        if (bc_ff != '0) begin
                           clr    = 1'b1;
                           rog    = 1'b1;
                           rog_oc = OC_TIMEOUT;
                        end else if (retry_ff != 4'd0 && retry_ff >= cfg.max_retries) begin
                           retry_in = 4'd0;
                           idle_in  = 16'd0;
                           emit     = 1'b1;
                           e_oc     = OC_GIVE_UP;
                        end
                     end
                  end
                  KIND_READ: begin
                     if (32'(item.read_index) < 32'(llen_ff) &&
                         32'(item.read_index) < 32'(BODY_MAX)) begin
                        ram_re    = 1'b1;
                        ram_raddr = (bank_ff ? BANK1_BASE : '0)
                                  + ADDR_W'(item.read_index);
                        state_in  = ST_READ;
                     end else begin
                        emit = 1'b1;
                        e_oc = OC_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GO: begin
            sha_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (sha_done) begin
               case (phase_ff)
                  PH_BODY: state_in = fin_ff ? ST_PAD1 : ST_IDLE;
                  PH_PAD1: state_in = two_blocks ? ST_PAD2 : ST_CMP;
                  default: state_in = ST_CMP;
               endcase
            end
         end
         ST_PAD1: begin
            hb_in    = pad1;
            phase_in = PH_PAD1;
            state_in = ST_GO;
         end
         ST_PAD2: begin
            hb_in    = pad2;
            phase_in = PH_PAD2;
            state_in = ST_GO;
         end
         ST_CMP: begin
            clr      = 1'b1;
            state_in = ST_IDLE;
            if (sha_digest == exp_ff) begin
               bank_in  = !bank_ff;
               llen_in  = LEN_W'(hl_ff);
               retry_in = 4'd0;
               if (hl_ff == 32'd0) begin
                  type_in = MT_UNKNOWN;
                  emit    = 1'b1;
                  e_oc    = OC_ACCEPT;
                  e_reply = cfg.ack_code;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = bank_ff ? '0 : BANK1_BASE;
                  state_in  = ST_TYPE;
               end
            end else begin
               rog    = 1'b1;
               rog_oc = OC_BAD_DIGEST;
            end
         end
         ST_TYPE: begin
            type_in  = new_type;
            emit     = 1'b1;
            e_oc     = OC_ACCEPT;
            e_reply  = cfg.ack_code;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            emit     = 1'b1;
            e_oc     = OC_READ;
            e_data   = ram_rdata;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clr) begin
         bc_in    = '0;
         hl_in    = 32'd0;
         bad_in   = 1'b0;
         idle_in  = 16'd0;
         sha_init = 1'b1;
      end
      if (rog) begin
         emit = 1'b1;
         if (retry_ff < cfg.max_retries) begin
            retry_in = retry_ff + 4'd1;
            e_oc     = rog_oc;
            e_reply  = cfg.nack_code;
         end else begin
            retry_in = 4'd0;
            e_oc     = OC_GIVE_UP;
         end
      end

      res_valid          = emit;
      res.outcome        = e_oc;
      res.reply_byte     = e_reply;
      res.message_type   = type_in;
      res.message_length = 11'(llen_in);
      res.read_data      = e_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_BODY;
         fin_ff   <= 1'b0;
         bc_ff    <= '0;
         hl_ff    <= 32'd0;
         bad_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         retry_ff <= 4'd0;
         idle_ff  <= 16'd0;
         type_ff  <= MT_UNKNOWN;
         llen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
         bc_ff    <= bc_in;
         hl_ff    <= hl_in;
         bad_ff   <= bad_in;
         bank_ff  <= bank_in;
         retry_ff <= retry_in;
         idle_ff  <= idle_in;
         type_ff  <= type_in;
         llen_ff  <= llen_in;
      end
      exp_ff <= exp_in;
      hb_ff  <= hb_in;
   end

   cfr_sha u_sha (
      .clock  (clock),
      .reset  (reset),
      .init   (sha_init),
      .start  (sha_start),
      .words  (sha_words),
      .busy   (sha_busy),
      .done   (sha_done),
      .digest (sha_digest)
   );

   cfr_ram #(
      .WIDTH (8),
      .DEPTH (2 * BODY_MAX)
   ) u_banks (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   a_res_slot_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !out_full)
      else $error("result produced while the output register is occupied");

   a_sha_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      sha_start |-> !sha_busy)
      else $error("hash compression started while the unit is busy");

   a_write_spare_bank: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((ram_waddr >= BANK1_BASE) == !bank_ff))
      else $error("body byte written into the readable bank");

endmodule

[rtl/checked_frame_receiver.sv]
// Top level of the checked frame receiver: register file, front end, core, output register.
//
// The receiver takes link bytes, time ticks and body reads as requests and
// returns at most one result per request. A frame is a 39-byte header
// (marker, 32-bit little-endian body length, marker, 32-byte SHA-256
// digest, marker) followed by the body, which is hashed as it arrives and
// written into the spare one of two body banks. A verified frame gives an
// ack and becomes readable; a digest mismatch or a partial-frame timeout
// gives a nack until the retry limit is reached. Requests enter a two-entry
// queue, so the input side keeps flowing while a result waits in the output
// register. Ticks, header bytes and out-of-range reads are handled in the
// idle state; a body read adds a state for the registered bank read. The
// core only takes a request while the output register is empty, so a
// result holds off the next request until it is taken. The byte that
// completes a 64-byte block holds the core while the SHA-256 unit runs its
// 64 rounds (one round per cycle) and adds the state. The last body byte
// adds a padding compression, or two of them when the last, partly filled
// block holds 56 to 63 bytes, then a compare state and, for an accepted
// non-empty body, a type lookup in the bank memory. The banks need no
// clearing after reset; reads only ever reach bytes of an accepted body.
module checked_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [7:0] rx_byte, [17:8] read_index
   input  logic [1:0]  req_tuser,  // [1:0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [7:0] reply_byte, [9:8] message_type,
                                   // [20:10] message_length, [28:21] read_data
   output logic [2:0]  rsp_tuser,  // [2:0] outcome
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import cfr_pkg::*;

   // Register indexes, taken from bits [4:2] of the byte address.
   localparam logic [2:0] REG_MARKER  = 3'd0;
   localparam logic [2:0] REG_ACK     = 3'd1;
   localparam logic [2:0] REG_NACK    = 3'd2;
   localparam logic [2:0] REG_TIME    = 3'd3;
   localparam logic [2:0] REG_INFO    = 3'd4;
   localparam logic [2:0] REG_CONTENT = 3'd5;
   localparam logic [2:0] REG_TIMEOUT = 3'd6;
   localparam logic [2:0] REG_RETRIES = 3'd7;

   cfg_type  cfg_ff, cfg_in;
   logic     csr_write;
   logic     item_valid, item_pop;
   item_type item;
   logic     res_valid;
   res_type  res;
   logic     out_valid_ff, out_valid_in;
   res_type  out_ff;

   // The register is written in the access phase of an APB write.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[4:2])
            REG_MARKER:  cfg_in.frame_marker           = csr_pwdata[7:0];
            REG_ACK:     cfg_in.ack_code               = csr_pwdata[7:0];
            REG_NACK:    cfg_in.nack_code              = csr_pwdata[7:0];
            REG_TIME:    cfg_in.time_type_code         = csr_pwdata[7:0];
            REG_INFO:    cfg_in.file_info_type_code    = csr_pwdata[7:0];
            REG_CONTENT: cfg_in.file_content_type_code = csr_pwdata[7:0];
            REG_TIMEOUT: cfg_in.timeout_ticks          = csr_pwdata[15:0];
            REG_RETRIES: cfg_in.max_retries            = csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_MARKER:  csr_prdata = {24'd0, cfg_ff.frame_marker};
         REG_ACK:     csr_prdata = {24'd0, cfg_ff.ack_code};
         REG_NACK:    csr_prdata = {24'd0, cfg_ff.nack_code};
         REG_TIME:    csr_prdata = {24'd0, cfg_ff.time_type_code};
         REG_INFO:    csr_prdata = {24'd0, cfg_ff.file_info_type_code};
         REG_CONTENT: csr_prdata = {24'd0, cfg_ff.file_content_type_code};
         REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         REG_RETRIES: csr_prdata = {28'd0, cfg_ff.max_retries};
         default:     csr_prdata = 32'd0;
      endcase
   end

   cfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   cfr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .out_full   (out_valid_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Output register: the core only starts a request when it is empty, so a
   // new result never meets one that has not been taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_marker           <= 8'd0;
         cfg_ff.ack_code               <= 8'd0;
         cfg_ff.nack_code              <= 8'd1;
         cfg_ff.time_type_code         <= 8'd0;
         cfg_ff.file_info_type_code    <= 8'd1;
         cfg_ff.file_content_type_code <= 8'd2;
         cfg_ff.timeout_ticks          <= 16'd1000;
         cfg_ff.max_retries            <= 4'd3;
         out_valid_ff                  <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
      if (res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.outcome;
   assign rsp_tdata  = {3'd0, out_ff.read_data, out_ff.message_length,
                        out_ff.message_type, out_ff.reply_byte};

endmodule
